// ===== hdl/tber_pkg.sv =====
// Shared types and constants for the token bucket rate limiter.
package tber_pkg;

    localparam int CAP_W      = 20;
    localparam int INTERVAL_W = 30;
    localparam int CFG_DATA_W = 30;
    localparam int CFG_IDX_W  = 1;
    localparam int TOKENS_W   = 20;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

    localparam logic [CAP_W-1:0]      CAP_RESET      = 20'd100;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 30'd10000000;

    typedef struct packed {
        logic load;    // capture timestamp, start divide
        logic step;    // one restoring divide step
        logic refill;  // add tokens, move reference time
        logic decide;  // grant/deny, load result register
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } stat_t;

endpackage

// ===== hdl/token_bucket_elapsed_refill_core.sv =====
// Token bucket rate limiter with elapsed-time refill: top level.
// Each request carries a timestamp from a wrapping TIME_WIDTH-bit counter. The
// elapsed time since the stored reference is divided by refill_interval with a
// one-bit-per-cycle restoring divider; the quotient refills the bucket up to
// bucket_capacity, the reference moves to now minus the remainder, and one token
// is taken if any is left. After the request is accepted, the divider runs
// TIME_WIDTH divide steps, then the refill and decide states follow; the
// decide state waits while a held result is stalled in the output register.
// One request is in flight at a time, so a new request is accepted only
// in idle. A new request is taken while the previous result still waits in
// the output register. Write configuration only while the block is idle.
module token_bucket_elapsed_refill_core #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [tber_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [tber_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [TIME_WIDTH-1:0]           request_time,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            granted,
    output logic [tber_pkg::TOKENS_W-1:0]   tokens_left
);
    import tber_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tber_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tber_datapath #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .request_time (request_time),
        .cmd          (cmd),
        .stat         (stat),
        .granted      (granted),
        .tokens_left  (tokens_left)
    );

endmodule

// ===== hdl/tber_datapath.sv =====
// Datapath: config registers, bucket state, bit-serial divider and result register.
module tber_datapath #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [tber_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [tber_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic [TIME_WIDTH-1:0]           request_time,
    input  tber_pkg::cmd_t                  cmd,
    output tber_pkg::stat_t                 stat,
    output logic                            granted,
    output logic [tber_pkg::TOKENS_W-1:0]   tokens_left
);
    import tber_pkg::*;

    localparam int CNT_W = $clog2(TIME_WIDTH);
    localparam logic [TIME_WIDTH-1:0] COUNT_MAX = TIME_WIDTH'({COUNT_WIDTH{1'b1}});

    logic [CAP_W-1:0]        cap_reg;
    logic [INTERVAL_W-1:0]   interval_reg;
    logic [COUNT_WIDTH-1:0]  token_reg, token_next;
    logic [TIME_WIDTH-1:0]   ref_reg;
    logic [TIME_WIDTH-1:0]   now_reg;
    logic [TIME_WIDTH-1:0]   quo_reg;
    logic [INTERVAL_W-1:0]   rem_reg, rem_next;
    logic [INTERVAL_W-1:0]   div_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    granted_reg;
    logic [TOKENS_W-1:0]     tokens_left_reg;

    logic [INTERVAL_W:0]     rem_shift;
    logic [INTERVAL_W+1:0]   rem_diff;
    logic                    qbit;
    logic [TIME_WIDTH-1:0]   cap_ext, cap_eff, tok_ext, refill_tokens;
    logic                    grant;

    // restoring divide step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[TIME_WIDTH-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, div_reg};
        qbit      = !rem_diff[INTERVAL_W+1];
        rem_next  = qbit ? rem_diff[INTERVAL_W-1:0] : rem_shift[INTERVAL_W-1:0];
    end

    // saturating refill
    always_comb
    begin
        cap_ext = TIME_WIDTH'(cap_reg);
        cap_eff = (cap_ext > COUNT_MAX) ? COUNT_MAX : cap_ext;
        tok_ext = TIME_WIDTH'(token_reg);
        if (tok_ext >= cap_eff || quo_reg >= cap_eff - tok_ext)
        begin
            refill_tokens = cap_eff;
        end
        else
        begin
            refill_tokens = tok_ext + quo_reg;
        end
    end

    assign grant      = (token_reg != '0);
    assign token_next = grant ? token_reg - COUNT_WIDTH'(1) : token_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            interval_reg <= INTERVAL_RESET;
            token_reg    <= '0;
            ref_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_CAPACITY: cap_reg      <= wr_data[CAP_W-1:0];
                    REG_INTERVAL: interval_reg <= wr_data[INTERVAL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.refill)
            begin
                token_reg <= COUNT_WIDTH'(refill_tokens);
                ref_reg   <= now_reg - TIME_WIDTH'(rem_reg);
            end
            else if (cmd.decide)
            begin
                token_reg <= token_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= request_time;
            quo_reg <= request_time - ref_reg;
            rem_reg <= '0;
            div_reg <= (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;
            cnt_reg <= CNT_W'(TIME_WIDTH - 1);
        end
        else if (cmd.step)
        begin
            quo_reg <= {quo_reg[TIME_WIDTH-2:0], qbit};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.decide)
        begin
            granted_reg     <= grant;
            tokens_left_reg <= TOKENS_W'(token_next);
        end
    end

    assign stat.div_last = (cnt_reg == '0);
    assign granted       = granted_reg;
    assign tokens_left   = tokens_left_reg;

endmodule

// ===== hdl/tber_ctrl.sv =====
// Controller: sequences load, divide, refill and decide for one request.
module tber_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  tber_pkg::stat_t stat,
    output tber_pkg::cmd_t  cmd
);
    import tber_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        DIVIDE,
        REFILL,
        DECIDE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.load   = (state_reg == IDLE) && in_valid;
        cmd.step   = (state_reg == DIVIDE);
        cmd.refill = (state_reg == REFILL);
        cmd.decide = (state_reg == DECIDE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= DIVIDE;
                    end
                end
                DIVIDE:
                begin
                    if (stat.div_last)
                    begin
                        state_reg <= REFILL;
                    end
                end
                REFILL:
                begin
                    state_reg <= DECIDE;
                end
                DECIDE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule
